### rtl/stip_pkg.sv
// shared types and constants of the string to integer parser
package stip_pkg;

	localparam int DigitW     = 6;
	localparam int BaseW      = 6;
	localparam int ValueW     = 64;
	localparam int CountW     = 16;
	localparam int QueueDepth = 2;
	localparam int QPtrW      = $clog2(QueueDepth);
	localparam int QCountW    = $clog2(QueueDepth + 1);

	// character count saturates at the smaller of the length limit and the field range
	localparam longint unsigned MaxChars = 64'd65535;
	localparam logic [CountW-1:0] CountCap =
		(MaxChars < 64'hFFFF) ? CountW'(MaxChars) : {CountW{1'b1}};

	// digit code for characters that are no digit in any base
	localparam logic [DigitW-1:0] DigitNone = {DigitW{1'b1}};

	// classified character, front to back
	typedef struct packed {
		logic              start;
		logic              is_ws;
		logic              is_plus;
		logic              is_minus;
		logic              is_zero;
		logic              is_x;
		logic [DigitW-1:0] digit;
	} item_t;

	// configuration as seen by the back end
	typedef struct packed {
		logic [BaseW-1:0] radix;
		logic             signed_mode;
	} cfg_t;

endpackage

### rtl/stip_front.sv
// front end: input handshake and character classification
module stip_front (
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        ch,
	input  logic              start_req,
	input  logic              q_full,
	output logic              q_push,
	output stip_pkg::item_t   q_item
);

	localparam logic [7:0] ChSpace = 8'h20;
	localparam logic [7:0] ChTab   = 8'h09;
	localparam logic [7:0] ChLf    = 8'h0A;
	localparam logic [7:0] ChVt    = 8'h0B;
	localparam logic [7:0] ChFf    = 8'h0C;
	localparam logic [7:0] ChCr    = 8'h0D;
	localparam logic [7:0] ChPlus  = 8'h2B;
	localparam logic [7:0] ChMinus = 8'h2D;
	localparam logic [7:0] ChZero  = 8'h30;
	localparam logic [7:0] ChNine  = 8'h39;
	localparam logic [7:0] ChUpA   = 8'h41;
	localparam logic [7:0] ChUpZ   = 8'h5A;
	localparam logic [7:0] ChLoA   = 8'h61;
	localparam logic [7:0] ChLoZ   = 8'h7A;
	localparam logic [7:0] ChUpX   = 8'h58;
	localparam logic [7:0] ChLoX   = 8'h78;

	function automatic logic [stip_pkg::DigitW-1:0] digit_of(input logic [7:0] c);
		logic [7:0] d;
		d = 8'd0;
		if (c >= ChZero && c <= ChNine) begin
			d = c - ChZero;
		end else if (c >= ChLoA && c <= ChLoZ) begin
			d = c - ChLoA + 8'd10;
		end else if (c >= ChUpA && c <= ChUpZ) begin
			d = c - ChUpA + 8'd10;
		end else begin
			d = 8'(stip_pkg::DigitNone);
		end
		return d[stip_pkg::DigitW-1:0];
	endfunction

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		q_item.start    = start_req;
		q_item.is_ws    = (ch == ChSpace) || (ch == ChTab) || (ch == ChLf) ||
		                  (ch == ChVt) || (ch == ChFf) || (ch == ChCr);
		q_item.is_plus  = (ch == ChPlus);
		q_item.is_minus = (ch == ChMinus);
		q_item.is_zero  = (ch == ChZero);
		q_item.is_x     = (ch == ChLoX) || (ch == ChUpX);
		q_item.digit    = digit_of(ch);
	end

endmodule

### rtl/stip_queue.sv
// two-entry queue of classified characters between front and back
module stip_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  stip_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output stip_pkg::item_t pop_item
);

	stip_pkg::item_t                 entry_q [stip_pkg::QueueDepth];
	logic [stip_pkg::QPtrW-1:0]      wr_ptr_q;
	logic [stip_pkg::QPtrW-1:0]      rd_ptr_q;
	logic [stip_pkg::QCountW-1:0]    count_q;

	assign full      = (count_q == stip_pkg::QCountW'(stip_pkg::QueueDepth));
	assign not_empty = (count_q != '0);
	assign pop_item  = entry_q[rd_ptr_q];

	function automatic logic [stip_pkg::QPtrW-1:0] ptr_next(
		input logic [stip_pkg::QPtrW-1:0] p);
		logic [stip_pkg::QPtrW-1:0] n;
		n = (p == stip_pkg::QPtrW'(stip_pkg::QueueDepth - 1)) ? '0 : p + 1'b1;
		return n;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/stip_back.sv
// back end: parse state, accumulator and result register
module stip_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  stip_pkg::cfg_t                cfg,
	input  logic                          q_not_empty,
	input  stip_pkg::item_t               q_item,
	output logic                          q_pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [stip_pkg::ValueW-1:0]   value,
	output logic [stip_pkg::CountW-1:0]   consumed
);

	localparam logic [2:0] PhIdle   = 3'd0;
	localparam logic [2:0] PhLead   = 3'd1;
	localparam logic [2:0] PhPrefix = 3'd2;
	localparam logic [2:0] PhZero   = 3'd3;
	localparam logic [2:0] PhHexp   = 3'd4;
	localparam logic [2:0] PhDigits = 3'd5;

	localparam logic [stip_pkg::BaseW-1:0] BaseAuto = stip_pkg::BaseW'(0);
	localparam logic [stip_pkg::BaseW-1:0] BaseMin  = stip_pkg::BaseW'(2);
	localparam logic [stip_pkg::BaseW-1:0] BaseMax  = stip_pkg::BaseW'(36);
	localparam logic [stip_pkg::BaseW-1:0] BaseOct  = stip_pkg::BaseW'(8);
	localparam logic [stip_pkg::BaseW-1:0] BaseDec  = stip_pkg::BaseW'(10);
	localparam logic [stip_pkg::BaseW-1:0] BaseHex  = stip_pkg::BaseW'(16);

	logic [2:0]                   phase_q;
	logic [stip_pkg::ValueW-1:0]  acc_q;
	logic                         neg_q;
	logic [stip_pkg::BaseW-1:0]   base_q;
	logic [stip_pkg::CountW-1:0]  cnt_q;
	logic                         hd_q;
	logic                         out_valid_q;
	logic [stip_pkg::ValueW-1:0]  value_q;
	logic [stip_pkg::CountW-1:0]  consumed_q;

	logic [2:0]                   st;
	logic [stip_pkg::ValueW-1:0]  acc;
	logic                         neg;
	logic [stip_pkg::BaseW-1:0]   base;
	logic [stip_pkg::CountW-1:0]  cnt;
	logic                         hd;
	logic                         done;
	logic                         emit;
	logic                         base_detect;
	logic                         base_ok;

	function automatic logic [stip_pkg::CountW-1:0] sat_add(
		input logic [stip_pkg::CountW-1:0] c, input logic [1:0] n);
		logic [stip_pkg::CountW:0] s;
		s = {1'b0, c} + (stip_pkg::CountW + 1)'(n);
		return (s >= (stip_pkg::CountW + 1)'(stip_pkg::CountCap)) ?
			stip_pkg::CountCap : s[stip_pkg::CountW-1:0];
	endfunction

	// shift-and-add over the base bits, wrapping modulo 2^64
	function automatic logic [stip_pkg::ValueW-1:0] mul_add(
		input logic [stip_pkg::ValueW-1:0] a,
		input logic [stip_pkg::BaseW-1:0]  b,
		input logic [stip_pkg::DigitW-1:0] d);
		logic [stip_pkg::ValueW-1:0] s;
		s = stip_pkg::ValueW'(d);
		for (int i = 0; i < stip_pkg::BaseW; i++) begin
			if (b[i]) begin
				s = s + (a << i);
			end
		end
		return s;
	endfunction

	assign q_pop = q_not_empty && (!out_valid_q || out_ready);

	always_comb begin
		st   = q_item.start ? PhLead : phase_q;
		base = q_item.start ? cfg.radix : base_q;
		acc  = q_item.start ? '0 : acc_q;
		neg  = q_item.start ? 1'b0 : neg_q;
		cnt  = q_item.start ? '0 : cnt_q;
		hd   = q_item.start ? 1'b0 : hd_q;
		done = 1'b0;
		emit = 1'b0;
		base_detect = 1'b0;
		base_ok     = 1'b0;

		if (st == PhIdle) begin
			done = 1'b1;
		end

		if (!done && st == PhLead) begin
			if (q_item.is_ws) begin
				cnt  = sat_add(cnt, 2'd1);
				done = 1'b1;
			end else if (q_item.is_plus || (q_item.is_minus && cfg.signed_mode)) begin
				neg  = neg | q_item.is_minus;
				cnt  = sat_add(cnt, 2'd1);
				st   = PhPrefix;
				done = 1'b1;
			end else begin
				st = PhPrefix;
			end
		end

		base_detect = (base == BaseAuto) || (base == BaseHex);
		if (!done) begin
			if (st == PhPrefix) begin
				if (q_item.is_zero && base_detect) begin
					cnt  = sat_add(cnt, 2'd1);
					hd   = 1'b1;
					st   = PhZero;
					done = 1'b1;
				end else begin
					if (base == BaseAuto) begin
						base = BaseDec;
					end
					st = PhDigits;
				end
			end else if (st == PhZero) begin
				if (q_item.is_x && base_detect) begin
					base = BaseHex;
					st   = PhHexp;
					done = 1'b1;
				end else begin
					if (base == BaseAuto) begin
						base = BaseOct;
					end
					st = PhDigits;
				end
			end else if (st == PhHexp) begin
				if (q_item.digit < stip_pkg::DigitW'(16)) begin
					acc  = stip_pkg::ValueW'(q_item.digit);
					cnt  = sat_add(cnt, 2'd2);
					st   = PhDigits;
					done = 1'b1;
				end
			end
		end

		base_ok = (base >= BaseMin) && (base <= BaseMax);
		if (!done && st == PhDigits) begin
			if (base_ok && q_item.digit < base) begin
				acc  = mul_add(acc, base, q_item.digit);
				cnt  = sat_add(cnt, 2'd1);
				hd   = 1'b1;
				done = 1'b1;
			end
		end

		if (!done) begin
			emit = 1'b1;
			st   = PhIdle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PhIdle;
			acc_q       <= '0;
			neg_q       <= 1'b0;
			base_q      <= '0;
			cnt_q       <= '0;
			hd_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				phase_q <= st;
				acc_q   <= acc;
				neg_q   <= neg;
				base_q  <= base;
				cnt_q   <= cnt;
				hd_q    <= hd;
			end
			if (q_pop && emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && emit) begin
			value_q    <= hd ? (neg ? stip_pkg::ValueW'(0) - acc : acc) : '0;
			consumed_q <= hd ? cnt : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign consumed  = consumed_q;

endmodule

### rtl/string_to_integer_parser.sv
// top level of the streaming string to integer parser
//
//  channel   direction  handshake             payload
//  input     in         in_valid / in_ready   ch, start_req
//  result    out        out_valid / out_ready value, consumed
//  config    in         apb psel/penable      paddr, pwdata -> prdata
//
// one character per cycle while in_ready is high; the character that ends the parse
// passes through the queue, and out_valid is registered when the back end pops it.
// the accumulator loop (value * base + digit) in the back end sets the rate.
// a two-entry queue takes up to two more characters while a result waits;
// the back end holds while the result register is full and not taken.
// reset clears parse state, queue and result valid; radix resets to 0, signed_mode to 1.
module string_to_integer_parser (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    ch,
	input  logic                          start_req,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [stip_pkg::ValueW-1:0]   value,
	output logic [stip_pkg::CountW-1:0]   consumed
);

	localparam logic RegRadix  = 1'b0;
	localparam logic RegSigned = 1'b1;

	logic [stip_pkg::BaseW-1:0] radix_q;
	logic                       signed_mode_q;
	logic                       cfg_wr;
	stip_pkg::cfg_t             cfg;
	logic                       q_full;
	logic                       q_push;
	stip_pkg::item_t            q_push_item;
	logic                       q_pop;
	logic                       q_not_empty;
	stip_pkg::item_t            q_pop_item;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q       <= '0;
			signed_mode_q <= 1'b1;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				RegRadix:  radix_q       <= pwdata[stip_pkg::BaseW-1:0];
				RegSigned: signed_mode_q <= pwdata[0];
				default:   radix_q       <= radix_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			RegRadix:  prdata = 32'(radix_q);
			RegSigned: prdata = 32'(signed_mode_q);
			default:   prdata = '0;
		endcase
	end

	assign cfg.radix       = radix_q;
	assign cfg.signed_mode = signed_mode_q;

	stip_front u_front (
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.ch        (ch),
		.start_req (start_req),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_item    (q_push_item)
	);

	stip_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_push_item),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_item  (q_pop_item)
	);

	stip_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.q_not_empty (q_not_empty),
		.q_item      (q_pop_item),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.value       (value),
		.consumed    (consumed)
	);

endmodule

### rtl/stip_checker.sv
// port-level checks of the parser, bound to the top level
module stip_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          pready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [stip_pkg::ValueW-1:0]   value,
	input logic [stip_pkg::CountW-1:0]   consumed
);

	// a stalled result transaction stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// no digit taken means an all-zero result
	a_zero_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && consumed == '0 |-> value == '0)
		else $error("nonzero value with zero consumed count");

	// stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(value) && $stable(consumed))
		else $error("result payload changed while stalled");

	// configuration port never waits
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready low");

endmodule

bind string_to_integer_parser stip_checker u_stip_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pready    (pready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.value     (value),
	.consumed  (consumed)
);
